>>> hw/rtl/fr_pkg.sv
// shared constants and types for the fragment reassembler
package fr_pkg;

    localparam int FRAME_CAPACITY = 256;
    localparam int POS_W          = $clog2(FRAME_CAPACITY + 1);
    localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
    localparam int BYTE_W         = 8;
    localparam int IDX_W          = 8;
    localparam int LEN_W          = 9;
    localparam int KIND_W         = 4;

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(FRAME_CAPACITY);

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_MIDDLE = 4'h0;
    localparam kind_t KIND_START  = 4'h1;
    localparam kind_t KIND_LAST   = 4'h2;
    localparam kind_t KIND_WHOLE  = 4'h3;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] len;
        logic             coll;
    } frag_status_t;

endpackage

>>> hw/rtl/fr_ctrl.sv
// fragment state tracking: header decode, store position and frame completion
module fr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       mode,
    input  logic [fr_pkg::BYTE_W-1:0]  data_byte,
    input  logic                       first_byte,
    input  logic                       last_byte,
    output fr_pkg::store_wr_t          wr,
    output fr_pkg::frag_status_t       status
);

    logic [fr_pkg::POS_W-1:0] write_pos_reg;
    logic [fr_pkg::POS_W-1:0] write_pos_next;
    logic [fr_pkg::POS_W-1:0] assembled_len_reg;
    logic [fr_pkg::POS_W-1:0] assembled_len_next;
    logic                     collecting_reg;
    logic                     collecting_next;
    fr_pkg::kind_t            fragment_kind_reg;
    fr_pkg::kind_t            fragment_kind_next;
    logic                     fragment_accepted_reg;
    logic                     fragment_accepted_next;
    logic                     end_now;
    logic                     done;
    logic                     store_en;

    always_comb
    begin
        write_pos_next         = write_pos_reg;
        assembled_len_next     = assembled_len_reg;
        collecting_next        = collecting_reg;
        fragment_kind_next     = fragment_kind_reg;
        fragment_accepted_next = fragment_accepted_reg;
        end_now                = 1'b0;
        done                   = 1'b0;
        store_en               = 1'b0;

        if (!mode)
        begin
            if (first_byte)
            begin
                fragment_kind_next = data_byte[fr_pkg::KIND_W-1:0];
                if (fragment_kind_next == fr_pkg::KIND_START ||
                    fragment_kind_next == fr_pkg::KIND_WHOLE)
                begin
                    write_pos_next         = '0;
                    assembled_len_next     = '0;
                    fragment_accepted_next = 1'b1;
                    collecting_next        = (fragment_kind_next == fr_pkg::KIND_START);
                end
                else if (fragment_kind_next == fr_pkg::KIND_MIDDLE ||
                         fragment_kind_next == fr_pkg::KIND_LAST)
                begin
                    fragment_accepted_next = collecting_reg;
                end
                else
                begin
                    fragment_accepted_next = 1'b0;
                end
                end_now = last_byte;
            end
            else if (fragment_accepted_reg)
            begin
                if (write_pos_reg < fr_pkg::CAP_POS)
                begin
                    store_en           = 1'b1;
                    write_pos_next     = write_pos_reg + fr_pkg::POS_W'(1);
                    assembled_len_next = write_pos_next;
                    end_now            = last_byte;
                end
                else
                begin
                    // overflow abandons the frame
                    collecting_next        = 1'b0;
                    fragment_accepted_next = 1'b0;
                end
            end
        end

        if (end_now)
        begin
            if (fragment_accepted_next)
            begin
                if (fragment_kind_next == fr_pkg::KIND_LAST ||
                    fragment_kind_next == fr_pkg::KIND_WHOLE)
                begin
                    done            = 1'b1;
                    collecting_next = 1'b0;
                end
                else if (fragment_kind_next == fr_pkg::KIND_MIDDLE &&
                         write_pos_next >= fr_pkg::CAP_POS)
                begin
                    collecting_next = 1'b0;
                end
            end
            fragment_accepted_next = 1'b0;
        end
    end

    always_comb
    begin
        wr.en       = accept & store_en;
        wr.addr     = write_pos_reg[fr_pkg::ADDR_W-1:0];
        wr.data     = data_byte;
        status.done = done;
        status.len  = assembled_len_next;
        status.coll = collecting_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg         <= '0;
            assembled_len_reg     <= '0;
            collecting_reg        <= 1'b0;
            fragment_kind_reg     <= '0;
            fragment_accepted_reg <= 1'b0;
        end
        else if (accept)
        begin
            write_pos_reg         <= write_pos_next;
            assembled_len_reg     <= assembled_len_next;
            collecting_reg        <= collecting_next;
            fragment_kind_reg     <= fragment_kind_next;
            fragment_accepted_reg <= fragment_accepted_next;
        end
    end

endmodule

>>> hw/rtl/fr_store.sv
// frame byte store with one write port and a registered read port
module fr_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fr_pkg::store_wr_t          wr,
    input  logic                       rd_en,
    input  logic [fr_pkg::IDX_W-1:0]   read_index,
    output logic [fr_pkg::BYTE_W-1:0]  rd_data
);

    localparam int CMP_W = (fr_pkg::POS_W > fr_pkg::IDX_W) ? fr_pkg::POS_W : fr_pkg::IDX_W;

    logic [fr_pkg::BYTE_W-1:0] mem [fr_pkg::FRAME_CAPACITY];
    logic [fr_pkg::BYTE_W-1:0] rd_data_reg;
    logic                      in_range_reg;
    logic                      in_range;
    logic [fr_pkg::ADDR_W-1:0] rd_addr;

    assign in_range = CMP_W'(read_index) < CMP_W'(fr_pkg::FRAME_CAPACITY);
    assign rd_addr  = fr_pkg::ADDR_W'(read_index);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            in_range_reg <= in_range;
        end
    end

    assign rd_data = in_range_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/fragment_reassembler.sv
// fragment reassembler top level: handshake, result register and assertions
// the result is registered and becomes valid in the cycle after the input transfer
// throughput: one item per cycle; the input stalls only while a held result is stalled
// the byte store is a single 256-entry memory, at most one write or one read per item
// reset clears all control state and the result register; the store is not cleared
module fragment_reassembler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [fr_pkg::BYTE_W-1:0]  data_byte,
    input  logic                       first_byte,
    input  logic                       last_byte,
    input  logic [fr_pkg::IDX_W-1:0]   read_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       frame_done,
    output logic [fr_pkg::LEN_W-1:0]   frame_length,
    output logic [fr_pkg::BYTE_W-1:0]  read_data,
    output logic                       assembling
);

    fr_pkg::store_wr_t         wr;
    fr_pkg::frag_status_t      status;
    logic                      accept;
    logic [fr_pkg::BYTE_W-1:0] rd_data;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      frame_done_reg;
    logic [fr_pkg::POS_W-1:0]  len_reg;
    logic                      assembling_reg;
    logic                      read_sel_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    fr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .wr         (wr),
        .status     (status)
    );

    fr_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_en      (accept & mode),
        .read_index (read_index),
        .rd_data    (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            frame_done_reg <= 1'b0;
            len_reg        <= '0;
            assembling_reg <= 1'b0;
            read_sel_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                frame_done_reg <= status.done;
                len_reg        <= status.len;
                assembling_reg <= status.coll;
                read_sel_reg   <= mode;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = frame_done_reg;
    assign frame_length = fr_pkg::LEN_W'(len_reg);
    assign assembling   = assembling_reg;
    assign read_data    = read_sel_reg ? rd_data : '0;

    a_done_ends_collect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> !assembling_reg)
        else $error("frame completed while still collecting");

    a_read_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && read_sel_reg |-> !frame_done_reg)
        else $error("read transfer reports frame completion");

    a_len_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> len_reg <= fr_pkg::CAP_POS)
        else $error("frame length beyond store capacity");

    a_store_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> accept && !mode && !first_byte)
        else $error("store written outside a payload transfer");

endmodule
